// File: hdl/duu_pkg.sv
// Package for the division-model undistortion unit.
// Holds widths, payload and configuration types, and the divider step functions.
// No dependencies.
package duu_pkg;

	localparam int COORD_BITS = 16;
	localparam int CW = 16;          // coordinate field width
	localparam int OW = 20;          // output coordinate width
	localparam int FW = 24;          // focal register width
	localparam int UW = 32;          // normalized offset width (Q.24)
	localparam int SQW = 40;         // square width
	localparam int R2W = 32;         // saturated squared radius width
	localparam int PW = 40;          // k * r2 product width after the shift
	localparam int DENW = 41;        // positive denominator width
	localparam int QW = 40;          // offset quotient width
	localparam int NORM_STEPS = 32;
	localparam int OFF_STEPS = 40;
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);

	localparam logic [CW-1:0] COORD_MASK = CW'((33'd1 << COORD_BITS) - 33'd1);
	localparam logic [SQW-1:0] SQ_SAT = SQW'(33'h0FFFFFFFF);
	localparam logic [R2W-1:0] R2_MAX = '1;
	localparam logic signed [DENW:0] ONE_Q24 = (DENW+1)'(25'd16777216);
	localparam logic signed [DENW:0] OUT_MAX = (DENW+1)'(20'sd524287);
	localparam logic signed [DENW:0] OUT_MIN = -(DENW+1)'(21'sd524288);

	typedef enum logic [2:0] {
		REG_FOCAL_X = 3'd0,
		REG_FOCAL_Y = 3'd1,
		REG_CENTER_X = 3'd2,
		REG_CENTER_Y = 3'd3,
		REG_DIST_COEFF = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [CW-1:0] in_x;
		logic [CW-1:0] in_y;
	} point_t;

	typedef struct packed {
		logic signed [OW-1:0] out_x;
		logic signed [OW-1:0] out_y;
		logic saturated;
		logic invalid;
	} result_t;

	typedef struct packed {
		logic [FW-1:0] focal_x;
		logic [FW-1:0] focal_y;
		logic [CW-1:0] center_x;
		logic [CW-1:0] center_y;
		logic signed [31:0] distortion_coeff;
	} cfg_t;

	// Classified item handed from the front part to the back part.
	typedef struct packed {
		logic [1:0][CW-1:0] pix;
		logic [1:0][CW-1:0] mag;
		logic [1:0] neg;
		logic [DENW-1:0] den;
		logic invalid;
	} work_t;

	// One restoring division step: returns {quotient bit, new remainder}.
	function automatic logic [FW:0] norm_step(logic [FW-1:0] rem, logic b, logic [FW-1:0] dv);
		logic [FW:0] t;
		t = {rem, b};
		if (t >= {1'b0, dv}) begin
			return {1'b1, FW'(t - {1'b0, dv})};
		end
		return {1'b0, t[FW-1:0]};
	endfunction

	function automatic logic [DENW:0] off_step(logic [DENW-1:0] rem, logic b,
			logic [DENW-1:0] dv);
		logic [DENW:0] t;
		t = {rem, b};
		if (t >= {1'b0, dv}) begin
			return {1'b1, DENW'(t - {1'b0, dv})};
		end
		return {1'b0, t[DENW-1:0]};
	endfunction

endpackage

// File: hdl/division_model_undistort_unit.sv
// Division-model lens undistortion unit: one point accepted per cycle, every cycle.
// Each point passes the 32-step normalizing dividers, the work queue and the
// 40-step offset dividers; result and result_valid are registered outputs.
// Throughput is one point per cycle; busy stays low, the receiver cannot stall.
// Reset restores the register defaults and empties the pipeline and queue.
module division_model_undistort_unit import duu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [2:0] cfg_addr,
	input logic [31:0] cfg_wdata,
	input logic start,
	output logic busy,
	input point_t point,
	output result_t result,
	output logic result_valid
);

	cfg_t cfg_q;
	logic push, full, pop;
	work_t push_word, pop_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.focal_x <= FW'(262144);
			cfg_q.focal_y <= FW'(262144);
			cfg_q.center_x <= CW'(10240);
			cfg_q.center_y <= CW'(7680);
			cfg_q.distortion_coeff <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_FOCAL_X: cfg_q.focal_x <= cfg_wdata[FW-1:0];
				REG_FOCAL_Y: cfg_q.focal_y <= cfg_wdata[FW-1:0];
				REG_CENTER_X: cfg_q.center_x <= cfg_wdata[CW-1:0];
				REG_CENTER_Y: cfg_q.center_y <= cfg_wdata[CW-1:0];
				REG_DIST_COEFF: cfg_q.distortion_coeff <= $signed(cfg_wdata);
				default: ;
			endcase
		end
	end

	assign busy = full;

	duu_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.take(start & ~busy),
		.point(point),
		.push(push),
		.word(push_word)
	);

	duu_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_word(push_word),
		.full(full),
		.pop(pop),
		.pop_word(pop_word)
	);

	duu_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.pop(pop),
		.word(pop_word),
		.result(result),
		.result_valid(result_valid)
	);

endmodule

// File: hdl/duu_front.sv
// Front part: accepts points, normalizes both offsets, forms r2 and the denominator.
// Uses duu_pkg; feeds the work queue.
module duu_front import duu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic take,
	input point_t point,
	output logic push,
	output work_t word
);

	logic vld_s [0:NORM_STEPS];
	logic [FW-1:0] rem_s [0:NORM_STEPS][2];
	logic [UW-1:0] quo_s [0:NORM_STEPS][2];
	logic [CW-1:0] mag_s [0:NORM_STEPS][2];
	logic [CW-1:0] pix_s [0:NORM_STEPS][2];
	logic neg_s [0:NORM_STEPS][2];
	logic ovf_s [0:NORM_STEPS][2];

	logic vld_s33, vld_s34, vld_s35;
	logic [SQW-1:0] sq_s33 [2];
	logic [R2W-1:0] r2_s34;
	logic [PW-1:0] prod_s35;
	logic kneg_s35;
	logic [CW-1:0] mag_s33 [2], mag_s34 [2], mag_s35 [2];
	logic [CW-1:0] pix_s33 [2], pix_s34 [2], pix_s35 [2];
	logic neg_s33 [2], neg_s34 [2], neg_s35 [2];

	logic [FW-1:0] feff [2];
	logic [CW-1:0] pin [2];
	logic [CW-1:0] ctr [2];
	logic signed [CW:0] dx [2];
	logic [CW-1:0] dmag [2];
	logic [SQW:0] r2_sum;
	logic [31:0] kmag;
	logic signed [DENW:0] den;

	always_comb begin
		feff[0] = (cfg.focal_x == '0) ? FW'(1) : cfg.focal_x;
		feff[1] = (cfg.focal_y == '0) ? FW'(1) : cfg.focal_y;
		pin[0] = point.in_x & COORD_MASK;
		pin[1] = point.in_y & COORD_MASK;
		ctr[0] = cfg.center_x;
		ctr[1] = cfg.center_y;
		for (int a = 0; a < 2; a++) begin
			dx[a] = $signed({1'b0, pin[a]}) - $signed({1'b0, ctr[a]});
			dmag[a] = dx[a][CW] ? CW'(-dx[a]) : dx[a][CW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s <= NORM_STEPS; s++) vld_s[s] <= 1'b0;
			vld_s33 <= 1'b0;
			vld_s34 <= 1'b0;
			vld_s35 <= 1'b0;
		end else begin
			vld_s[0] <= take;
			for (int s = 0; s < NORM_STEPS; s++) vld_s[s+1] <= vld_s[s];
			vld_s33 <= vld_s[NORM_STEPS];
			vld_s34 <= vld_s33;
			vld_s35 <= vld_s34;
		end
	end

	// The quotient mag * 2^28 / f overflows 32 bits exactly when mag >= 16 * f.
	always_ff @(posedge clk) begin
		for (int a = 0; a < 2; a++) begin
			rem_s[0][a] <= FW'(dmag[a] >> 4);
			quo_s[0][a] <= '0;
			mag_s[0][a] <= dmag[a];
			pix_s[0][a] <= pin[a];
			neg_s[0][a] <= dx[a][CW];
			ovf_s[0][a] <= ({(FW+4)'(0), dmag[a]} >= {(CW)'(0), feff[a], 4'b0});
			for (int s = 0; s < NORM_STEPS; s++) begin
				logic [FW:0] st;
				st = norm_step(rem_s[s][a],
					(s < 4) ? mag_s[s][a][(s < 4) ? 3 - s : 0] : 1'b0, feff[a]);
				rem_s[s+1][a] <= st[FW-1:0];
				quo_s[s+1][a] <= {quo_s[s][a][UW-2:0], st[FW]};
				mag_s[s+1][a] <= mag_s[s][a];
				pix_s[s+1][a] <= pix_s[s][a];
				neg_s[s+1][a] <= neg_s[s][a];
				ovf_s[s+1][a] <= ovf_s[s][a];
			end
			sq_s33[a] <= ovf_s[NORM_STEPS][a] ? SQ_SAT :
				SQW'((64'(quo_s[NORM_STEPS][a]) * 64'(quo_s[NORM_STEPS][a])) >> 24);
			mag_s33[a] <= mag_s[NORM_STEPS][a];
			pix_s33[a] <= pix_s[NORM_STEPS][a];
			neg_s33[a] <= neg_s[NORM_STEPS][a];
			mag_s34[a] <= mag_s33[a];
			pix_s34[a] <= pix_s33[a];
			neg_s34[a] <= neg_s33[a];
			mag_s35[a] <= mag_s34[a];
			pix_s35[a] <= pix_s34[a];
			neg_s35[a] <= neg_s34[a];
		end
		r2_s34 <= (r2_sum > (SQW+1)'(R2_MAX)) ? R2_MAX : r2_sum[R2W-1:0];
		prod_s35 <= PW'((64'(kmag) * 64'(r2_s34)) >> 24);
		kneg_s35 <= cfg.distortion_coeff[31];
	end

	always_comb begin
		r2_sum = (SQW+1)'(sq_s33[0]) + (SQW+1)'(sq_s33[1]);
		kmag = cfg.distortion_coeff[31] ? 32'(-cfg.distortion_coeff) : cfg.distortion_coeff;
		den = kneg_s35 ? (ONE_Q24 - $signed({2'b0, prod_s35}))
			: (ONE_Q24 + $signed({2'b0, prod_s35}));
		push = vld_s35;
		for (int a = 0; a < 2; a++) begin
			word.pix[a] = pix_s35[a];
			word.mag[a] = mag_s35[a];
			word.neg[a] = neg_s35[a];
		end
		word.den = den[DENW-1:0];
		word.invalid = den[DENW] | (den == '0);
	end

endmodule

// File: hdl/duu_fifo.sv
// Short work queue between the front and back parts.
// Uses duu_pkg for the work word type and depth.
module duu_fifo import duu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input work_t push_word,
	output logic full,
	output logic pop,
	output work_t pop_word
);

	work_t mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0] count_q;

	// The back part never stalls, so a word leaves as soon as one is held.
	assign pop = (count_q != '0);
	assign full = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign pop_word = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= FIFO_AW'((FIFO_AW+1)'(wr_ptr_q) + 1'b1 == FIFO_DEPTH ? 0
				: wr_ptr_q + 1'b1);
			if (pop) rd_ptr_q <= FIFO_AW'((FIFO_AW+1)'(rd_ptr_q) + 1'b1 == FIFO_DEPTH ? 0
				: rd_ptr_q + 1'b1);
			count_q <= count_q + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
		end
	end

endmodule

// File: hdl/duu_back.sv
// Back part: divides both offsets by the denominator, recenters and saturates.
// Uses duu_pkg; takes words from the work queue.
module duu_back import duu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic pop,
	input work_t word,
	output result_t result,
	output logic result_valid
);

	logic vld_s [0:OFF_STEPS];
	logic [DENW-1:0] rem_s [0:OFF_STEPS][2];
	logic [QW-1:0] quo_s [0:OFF_STEPS][2];
	work_t wk_s [0:OFF_STEPS];
	result_t result_q;
	logic valid_q;

	logic [CW-1:0] ctr [2];
	logic signed [DENW:0] val [2];
	logic signed [OW-1:0] clip [2];
	logic [1:0] sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s <= OFF_STEPS; s++) vld_s[s] <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			vld_s[0] <= pop;
			for (int s = 0; s < OFF_STEPS; s++) vld_s[s+1] <= vld_s[s];
			valid_q <= vld_s[OFF_STEPS];
		end
	end

	// Numerator is mag * 2^24: the magnitude bits enter first, then zeros.
	always_ff @(posedge clk) begin
		wk_s[0] <= word;
		for (int a = 0; a < 2; a++) begin
			rem_s[0][a] <= '0;
			quo_s[0][a] <= '0;
		end
		for (int s = 0; s < OFF_STEPS; s++) begin
			wk_s[s+1] <= wk_s[s];
			for (int a = 0; a < 2; a++) begin
				logic [DENW:0] st;
				st = off_step(rem_s[s][a],
					(s < CW) ? wk_s[s].mag[a][(s < CW) ? CW - 1 - s : 0] : 1'b0,
					wk_s[s].den);
				rem_s[s+1][a] <= st[DENW-1:0];
				quo_s[s+1][a] <= {quo_s[s][a][QW-2:0], st[DENW]};
			end
		end
		result_q.out_x <= clip[0];
		result_q.out_y <= clip[1];
		result_q.saturated <= |sat;
		result_q.invalid <= wk_s[OFF_STEPS].invalid;
	end

	always_comb begin
		ctr[0] = cfg.center_x;
		ctr[1] = cfg.center_y;
		for (int a = 0; a < 2; a++) begin
			if (wk_s[OFF_STEPS].invalid) begin
				val[a] = $signed({(DENW+1-CW)'(0), wk_s[OFF_STEPS].pix[a]});
			end else if (wk_s[OFF_STEPS].neg[a]) begin
				val[a] = $signed({(DENW+1-CW)'(0), ctr[a]})
					- $signed({2'b0, quo_s[OFF_STEPS][a]});
			end else begin
				val[a] = $signed({(DENW+1-CW)'(0), ctr[a]})
					+ $signed({2'b0, quo_s[OFF_STEPS][a]});
			end
			sat[a] = 1'b0;
			if (val[a] > OUT_MAX) begin
				clip[a] = OW'(OUT_MAX);
				sat[a] = 1'b1;
			end else if (val[a] < OUT_MIN) begin
				clip[a] = OW'(OUT_MIN);
				sat[a] = 1'b1;
			end else begin
				clip[a] = val[a][OW-1:0];
			end
		end
	end

	assign result = result_q;
	assign result_valid = valid_q;

endmodule

// File: tb/tb_division_model_undistort_unit.sv
// Testbench for the division-model lens undistortion unit.
// Drives points and register writes, predicts each undistorted point and checks it.
// Depends on duu_pkg and division_model_undistort_unit.
`timescale 1ns / 1ps

module tb_division_model_undistort_unit;
	import duu_pkg::*;

	// Keeps the register image, computes the expected undistorted point
	// and holds the points still in flight.
	class undistort_scoreboard;
		logic [FW-1:0] focal_x, focal_y;
		logic [CW-1:0] center_x, center_y;
		logic signed [31:0] coeff;
		result_t pending[$];
		int errors;

		function new();
			focal_x = 24'd262144;
			focal_y = 24'd262144;
			center_x = 16'd10240;
			center_y = 16'd7680;
			coeff = 32'sd0;
			errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] data);
			case (cfg_reg_t'(idx))
				REG_FOCAL_X: focal_x = data[FW-1:0];
				REG_FOCAL_Y: focal_y = data[FW-1:0];
				REG_CENTER_X: center_x = data[CW-1:0];
				REG_CENTER_Y: center_y = data[CW-1:0];
				REG_DIST_COEFF: coeff = data;
				default: ;
			endcase
		endfunction

		// Squared normalized offset in Q.24; an overflowing quotient saturates it to 32 bits.
		function longint unsigned norm_square(longint signed dx, logic [FW-1:0] f);
			longint unsigned mag, fd, u;
			mag = dx < 0 ? -dx : dx;
			fd = (f == 0) ? 1 : f;
			u = (mag << 28) / fd;
			if (u >= 64'h1_0000_0000)
				return 64'hFFFF_FFFF;
			return (u * u) >> 24;
		endfunction

		function longint signed scale_axis(longint signed dx, longint signed den,
				longint signed c);
			longint unsigned mag, off;
			mag = dx < 0 ? -dx : dx;
			off = (mag << 24) / longint'(den);
			return dx < 0 ? c - longint'(off) : c + longint'(off);
		endfunction

		function longint signed clamp(longint signed v, inout bit sat);
			if (v > 524287) begin
				sat = 1;
				return 524287;
			end
			if (v < -524288) begin
				sat = 1;
				return -524288;
			end
			return v;
		endfunction

		function void note_point(point_t p);
			longint signed px, py, dx, dy, kr, den, rx, ry;
			longint unsigned r2, kmag, prod;
			bit sat;
			result_t r;
			sat = 0;
			px = p.in_x & COORD_MASK;
			py = p.in_y & COORD_MASK;
			dx = px - center_x;
			dy = py - center_y;
			r2 = norm_square(dx, focal_x) + norm_square(dy, focal_y);
			if (r2 > 64'hFFFF_FFFF)
				r2 = 64'hFFFF_FFFF;
			kmag = coeff < 0 ? -longint'(coeff) : longint'(coeff);
			prod = (kmag * r2) >> 24;
			kr = coeff < 0 ? -longint'(prod) : longint'(prod);
			den = 64'sd16777216 + kr;
			r.invalid = (den <= 0);
			if (r.invalid) begin
				rx = px;
				ry = py;
			end else begin
				rx = scale_axis(dx, den, center_x);
				ry = scale_axis(dy, den, center_y);
			end
			rx = clamp(rx, sat);
			ry = clamp(ry, sat);
			r.out_x = rx[OW-1:0];
			r.out_y = ry[OW-1:0];
			r.saturated = sat;
			pending.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t exp;
			if (pending.size() == 0) begin
				$error("unexpected result word %h", got);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.out_x !== exp.out_x) begin
				$error("out_x: expected %0d, got %0d", exp.out_x, got.out_x);
				errors++;
			end
			if (got.out_y !== exp.out_y) begin
				$error("out_y: expected %0d, got %0d", exp.out_y, got.out_y);
				errors++;
			end
			if (got.saturated !== exp.saturated) begin
				$error("saturated: expected %0b, got %0b", exp.saturated, got.saturated);
				errors++;
			end
			if (got.invalid !== exp.invalid) begin
				$error("invalid: expected %0b, got %0b", exp.invalid, got.invalid);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_addr;
	logic [31:0] cfg_wdata;
	logic start;
	logic busy;
	point_t point;
	result_t result;
	logic result_valid;

	undistort_scoreboard sb = new();

	division_model_undistort_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.start(start),
		.busy(busy),
		.point(point),
		.result(result),
		.result_valid(result_valid)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Inputs are driven with nonblocking assignments, so this sees pre-edge values.
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			sb.note_point(point);
		if (arst_n && result_valid)
			sb.check_result(result);
	end

	task automatic wait_idle();
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Back-to-back register writes; the caller lowers the write enable afterwards.
	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic configure(logic [23:0] fx, logic [23:0] fy, logic [15:0] cx,
			logic [15:0] cy, logic [31:0] k);
		write_reg(REG_FOCAL_X, {8'h00, fx});
		write_reg(REG_FOCAL_Y, {8'h00, fy});
		write_reg(REG_CENTER_X, {16'h0000, cx});
		write_reg(REG_CENTER_Y, {16'h0000, cy});
		write_reg(REG_DIST_COEFF, k);
		// Indexes past the last register must be ignored.
		write_reg(3'(5 + $urandom_range(0, 2)), $urandom());
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_point(logic [15:0] x, logic [15:0] y, int gap);
		start <= 1'b1;
		point <= '{in_x: x, in_y: y};
		do
			@(posedge clk);
		while (busy);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [15:0] pick_coord(logic [15:0] c);
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			1, 2: return c + 16'($urandom_range(0, 64)) - 16'd32;
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic run_phase(int count, bit pause_midway);
		int gap;
		bit no_gaps;
		logic [15:0] corner [6] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE};
		no_gaps = 0;
		for (int i = 0; i < 6; i++)
			send_point(corner[i], corner[5 - i], 0);
		send_point(sb.center_x, sb.center_y, 0);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 31) == 0)
				no_gaps = !no_gaps;
			gap = no_gaps ? 0 : $urandom_range(0, 6);
			if (pause_midway && i == count / 2 && gap == 0)
				gap = 1;
			send_point(pick_coord(sb.center_x), pick_coord(sb.center_y), gap);
			if (pause_midway && i == count / 2)
				wait_idle();
		end
		start <= 1'b0;
		wait_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		start = 1'b0;
		point = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_phase(120, 1);
		configure(24'd262144, 24'd262144, 16'd10240, 16'd7680, 32'h0040_0000);
		run_phase(110, 0);
		// Strongly negative coefficient: most points far out are invalid.
		configure(24'd262144, 24'd262144, 16'd10240, 16'd7680, 32'hFF80_0000);
		run_phase(110, 0);
		// Denominator close to zero near the edge gives huge offsets.
		configure(24'd262144, 24'd262144, 16'd10240, 16'd7680, -32'sd1509949);
		run_phase(110, 1);
		configure(24'd0, 24'hFFFFFF, 16'd0, 16'hFFFF, 32'h7FFF_FFFF);
		run_phase(110, 0);
		configure(24'd256, 24'd256, 16'hFFFF, 16'd0, 32'h8000_0000);
		run_phase(110, 0);
		configure(24'hFFFFFF, 24'hFFFFFF, 16'h8000, 16'h8000, 32'h0000_0001);
		run_phase(100, 0);
		configure(24'd4096, 24'd1, 16'd100, 16'd60000, 32'hFFFF_0000);
		run_phase(100, 0);
		configure(24'($urandom_range(256, 24'hFFFFFF)), 24'($urandom_range(256, 24'hFFFFFF)),
			16'($urandom()), 16'($urandom()), 32'($signed(20'($urandom()))));
		run_phase(100, 0);

		repeat (100) @(posedge clk);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#(12 * 200000);
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: files.f
hdl/duu_pkg.sv
hdl/duu_front.sv
hdl/duu_fifo.sv
hdl/duu_back.sv
hdl/division_model_undistort_unit.sv
tb/tb_division_model_undistort_unit.sv
